### design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold outside reset
`define XSCM_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition seen");

// ante at an edge implies cons at the same edge
`define XSCM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

`endif

### design/xscm_pkg.sv
// Types and constants for the marker-skipping XOR stream cipher.
`timescale 1ns / 1ps

package xscm_pkg;

    localparam logic [3:0]  KEY_LAST = 4'd8;
    localparam logic [2:0]  WIN_LEN = 3'd7;
    localparam logic [2:0]  MARK_TAIL = 3'd6;

    localparam logic [7:0] MARK_BYTES [7] = '{
        8'h5C, 8'h66, 8'h69, 8'h6E, 8'h61, 8'h6C, 8'h5C
    };

    // op kinds passed from front to back
    localparam logic [1:0] OP_CIPHER     = 2'd0;
    localparam logic [1:0] OP_MARK_START = 2'd1;
    localparam logic [1:0] OP_MARK_PASS  = 2'd2;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
    } op_t;

    typedef struct packed {
        logic       flushing;
        logic [2:0] pass_cnt;
    } front_stat_t;

    function automatic logic [7:0] key_byte(input logic [3:0] idx);
        logic [7:0] k;
        unique case (idx)
            4'd0:    k = 8'h47;
            4'd1:    k = 8'h61;
            4'd2:    k = 8'h6D;
            4'd3:    k = 8'h65;
            4'd4:    k = 8'h53;
            4'd5:    k = 8'h70;
            4'd6:    k = 8'h79;
            4'd7:    k = 8'h33;
            4'd8:    k = 8'h44;
            default: k = 8'h47;
        endcase
        return k;
    endfunction

endpackage

### design/xor_stream_cipher_marker_skip_unit.sv
// Top level of the marker-skipping repeating-key XOR stream cipher.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// XORs each byte of a buffer with a repeating 9-byte key whose position carries
// across buffers; a 7-byte frame marker found wholly inside the buffer passes
// unchanged and restarts the key. Output lags input by the 7-byte lookahead
// window, then by the queue and the output register. While the queue has room,
// one byte is taken per cycle; the byte marked tlast makes the front flush its
// window of up to 7 bytes, one byte per cycle while the queue has room; s_axis_tready
// is low meanwhile. The front-to-back queue's single push port sets the flush rate.
module xor_stream_cipher_marker_skip_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast
);
    import xscm_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic          push;
    op_t           push_op;
    logic          q_full;
    logic          q_empty;
    logic          pop;
    op_t           head;
    logic [CW-1:0] q_count;
    front_stat_t   fstat;
    logic [3:0]    key_pos;

    xscm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_eob   (s_axis_tlast),
        .push     (push),
        .push_op  (push_op),
        .q_full   (q_full),
        .stat     (fstat)
    );

    xscm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (pop),
        .empty   (q_empty),
        .head    (head),
        .count   (q_count)
    );

    xscm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (!q_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .key_pos   (key_pos)
    );

    `XSCM_ASSERT_IMP(a_no_accept_in_flush, fstat.flushing, !s_axis_tready)
    `XSCM_ASSERT_NEVER(a_key_pos_range, key_pos > KEY_LAST)
    `XSCM_ASSERT_NEVER(a_pass_cnt_range, fstat.pass_cnt > MARK_TAIL)
    `XSCM_ASSERT_NEVER(a_queue_bound, q_count > CW'(QUEUE_DEPTH))

endmodule

### design/xscm_front.sv
// Front end: lookahead window, marker detection and buffer flush.
`timescale 1ns / 1ps

module xscm_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_byte,
    input  logic                  in_eob,
    output logic                  push,
    output xscm_pkg::op_t         push_op,
    input  logic                  q_full,
    output xscm_pkg::front_stat_t stat
);
    import xscm_pkg::*;

    logic [7:0] win_reg [7];
    logic [7:0] win_next [7];
    logic [2:0] fill_reg, fill_next;
    logic [2:0] pass_reg, pass_next;
    logic       flush_reg, flush_next;

    logic [7:0] ew [7];
    logic [2:0] ef;
    logic       accept;
    logic       match;
    logic [1:0] kind;
    logic [2:0] pass_after;

    assign in_ready = !flush_reg && !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        ew = win_reg;
        ef = fill_reg;
        if (!flush_reg)
        begin
            ew[fill_reg] = in_byte;
            ef = 3'(fill_reg + 3'd1);
        end

        match = (ef == WIN_LEN);
        for (int i = 0; i < 7; i++)
        begin
            if (ew[i] != MARK_BYTES[i])
                match = 1'b0;
        end

        if (pass_reg != 3'd0)
        begin
            kind       = OP_MARK_PASS;
            pass_after = 3'(pass_reg - 3'd1);
        end
        else if (match)
        begin
            kind       = OP_MARK_START;
            pass_after = MARK_TAIL;
        end
        else
        begin
            kind       = OP_CIPHER;
            pass_after = 3'd0;
        end

        push = flush_reg ? !q_full : (accept && !in_eob && ef == WIN_LEN);
        push_op.data = ew[0];
        push_op.kind = kind;
        push_op.last = flush_reg && (fill_reg == 3'd1);

        win_next   = win_reg;
        fill_next  = fill_reg;
        pass_next  = pass_reg;
        flush_next = flush_reg;

        if (accept)
        begin
            win_next  = ew;
            fill_next = ef;
            if (in_eob)
                flush_next = 1'b1;
        end

        if (push)
        begin
            for (int i = 0; i < 6; i++)
                win_next[i] = ew[i + 1];
            fill_next = 3'(ef - 3'd1);
            pass_next = pass_after;
            if (flush_reg && fill_reg == 3'd1)
            begin
                flush_next = 1'b0;
                pass_next  = 3'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= 3'd0;
            pass_reg  <= 3'd0;
            flush_reg <= 1'b0;
        end
        else
        begin
            fill_reg  <= fill_next;
            pass_reg  <= pass_next;
            flush_reg <= flush_next;
        end
    end

    assign stat.flushing = flush_reg;
    assign stat.pass_cnt = pass_reg;

endmodule

### design/xscm_queue.sv
// Small FIFO of classified items between front and back.
`timescale 1ns / 1ps

module xscm_queue #(
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  xscm_pkg::op_t                push_op,
    output logic                         full,
    input  logic                         pop,
    output logic                         empty,
    output xscm_pkg::op_t                head,
    output logic [$clog2(DEPTH+1)-1:0]   count
);
    import xscm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    op_t           mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];
    assign count   = cnt_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
        if (do_push && !do_pop)
            cnt_next = CW'(cnt_reg + 1'b1);
        else if (do_pop && !do_push)
            cnt_next = CW'(cnt_reg - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### design/xscm_back.sv
// Back end: key position, XOR and output register.
`timescale 1ns / 1ps

module xscm_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  xscm_pkg::op_t head,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          out_last,
    output logic [3:0]    key_pos
);
    import xscm_pkg::*;

    logic [3:0] kp_reg, kp_next;
    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       last_reg, last_next;

    assign pop = q_valid && (!valid_reg || out_ready);

    always_comb
    begin
        kp_next    = kp_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            last_next  = head.last;
            unique case (head.kind)
                OP_CIPHER:
                begin
                    data_next = head.data ^ key_byte(kp_reg);
                    kp_next   = (kp_reg >= KEY_LAST) ? 4'd0 : 4'(kp_reg + 4'd1);
                end
                OP_MARK_START:
                begin
                    data_next = head.data;
                    kp_next   = 4'd0;
                end
                default:
                begin
                    data_next = head.data;
                end
            endcase
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg    <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            kp_reg    <= kp_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = data_reg;
    assign out_last  = last_reg;
    assign key_pos   = kp_reg;

endmodule

### dv/tb_top.sv
// Testbench for the marker-skipping repeating-key XOR stream cipher.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [55:0] MARKER = 56'h5C6C616E69665C;  // lowest byte first
    localparam int          MARK_N = 7;

    typedef struct packed {
        logic [7:0] b;
        logic       eob;
    } in_item_t;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } out_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data = 8'h00;
    logic       s_last = 1'b0;
    logic       m_ready = 1'b0;
    logic       in_taken = 1'b0;
    wire        s_axis_tready;
    wire        m_axis_tvalid;
    wire [7:0]  m_axis_tdata;
    wire        m_axis_tlast;

    in_item_t   pend_q [$];
    out_item_t  cipher_q [$];
    int         acc_cnt = 0;
    int         fail_cnt = 0;
    wire        calm = (acc_cnt >= 150) && (acc_cnt < 260);

    // predictor state
    logic [3:0] key_pos = 4'd0;
    logic [7:0] win [MARK_N];
    logic [2:0] fill = 3'd0;
    logic [2:0] pass_cnt = 3'd0;

    xor_stream_cipher_marker_skip_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),        // [7:0] in_byte
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),  // [7:0] out_byte
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [7:0] key_at(input logic [3:0] idx);
        logic [7:0] k;
        case (idx)
            4'd0:    k = 8'h47;
            4'd1:    k = 8'h61;
            4'd2:    k = 8'h6D;
            4'd3:    k = 8'h65;
            4'd4:    k = 8'h53;
            4'd5:    k = 8'h70;
            4'd6:    k = 8'h79;
            4'd7:    k = 8'h33;
            4'd8:    k = 8'h44;
            default: k = 8'h47;
        endcase
        return k;
    endfunction

    task automatic emit_oldest(output logic [7:0] r);
        logic hit;
        logic [3:0] kp;
        hit = (fill == 3'd7);
        for (int i = 0; i < MARK_N; i++)
            if (win[i] != MARKER[8*i +: 8])
                hit = 1'b0;
        if (pass_cnt != 3'd0) begin
            r = win[0];
            pass_cnt = pass_cnt - 3'd1;
        end else if (hit) begin
            r = win[0];
            pass_cnt = 3'd6;
            key_pos = 4'd0;
        end else begin
            kp = (key_pos < 4'd9) ? key_pos : 4'd0;
            r = win[0] ^ key_at(kp);
            key_pos = (kp == 4'd8) ? 4'd0 : kp + 4'd1;
        end
        for (int i = 1; i < MARK_N; i++)
            win[i-1] = win[i];
        win[MARK_N-1] = 8'h00;
        if (fill != 3'd0)
            fill = fill - 3'd1;
    endtask

    task automatic predict_cipher(input logic [7:0] b, input logic eob);
        out_item_t o;
        int n;
        n = 0;
        if (fill >= 3'd7)
            fill = 3'd6;
        win[fill] = b;
        fill = fill + 3'd1;
        if (!eob) begin
            if (fill == 3'd7) begin
                emit_oldest(o.b);
                o.last = 1'b0;
                cipher_q.push_back(o);
            end
        end else begin
            while (fill != 3'd0 && n < MARK_N) begin
                emit_oldest(o.b);
                n++;
                o.last = (fill == 3'd0) || (n == MARK_N);
                cipher_q.push_back(o);
            end
            fill = 3'd0;
            pass_cnt = 3'd0;
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        in_item_t it;
        if (rst_n) begin
            if (!s_valid || in_taken) begin
                if (pend_q.size() > 0 && (calm || $urandom_range(99) >= 16)) begin
                    it = pend_q.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= it.b;
                    s_last  <= it.eob;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= calm || ($urandom_range(99) >= 16);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        out_item_t e;
        in_taken <= s_valid && s_axis_tready;
        if (rst_n && s_valid && s_axis_tready) begin
            predict_cipher(s_data, s_last);
            acc_cnt <= acc_cnt + 1;
        end
        if (rst_n && m_axis_tvalid && m_ready) begin
            if (cipher_q.size() == 0) begin
                $error("unexpected item: out_byte %h last_of_buffer %b",
                       m_axis_tdata, m_axis_tlast);
                fail_cnt++;
            end else begin
                e = cipher_q.pop_front();
                if (m_axis_tdata !== e.b) begin
                    $error("out_byte: expected %h actual %h", e.b, m_axis_tdata);
                    fail_cnt++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last_of_buffer: expected %b actual %b", e.last, m_axis_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    task automatic add_byte(input logic [7:0] b, input logic eob);
        in_item_t it;
        it.b = b;
        it.eob = eob;
        pend_q.push_back(it);
    endtask

    task automatic add_marker(input int n, input logic eob_at_end);
        for (int i = 0; i < n; i++)
            add_byte(MARKER[8*i +: 8], eob_at_end && (i == n - 1));
    endtask

    task automatic add_random_buffers(input int target);
        logic [7:0] q [$];
        int made;
        int len;
        int r;
        int k;
        int bad;
        made = 0;
        while (made < target) begin
            q.delete();
            len = ($urandom_range(9) == 0) ? $urandom_range(48, 25) : $urandom_range(24, 1);
            while (q.size() < len) begin
                r = $urandom_range(99);
                if (r < 30) begin
                    bad = ($urandom_range(4) == 0) ? $urandom_range(6) : -1;
                    for (int i = 0; i < MARK_N; i++)
                        q.push_back((i == bad) ? 8'($urandom) : MARKER[8*i +: 8]);
                end else if (r < 40) begin
                    k = $urandom_range(6, 1);
                    for (int i = 0; i < k; i++)
                        q.push_back(MARKER[8*i +: 8]);
                end else begin
                    q.push_back(8'($urandom));
                end
            end
            if ($urandom_range(1) == 0)
                while (q.size() > len)
                    void'(q.pop_back());
            for (int i = 0; i < q.size(); i++)
                add_byte(q[i], i == q.size() - 1);
            made += q.size();
        end
    endtask

    task automatic wait_drained();
        while (pend_q.size() > 0 || s_valid || cipher_q.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < MARK_N; i++)
            win[i] = 8'h00;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // one-byte buffer
        add_byte(8'h00, 1'b1);
        // marker wholly inside the buffer
        add_byte(8'hFF, 1'b0);
        add_marker(7, 1'b0);
        add_byte(8'h00, 1'b1);
        // marker ending on the last byte of the buffer
        add_marker(7, 1'b1);
        // partial marker at the flush is enciphered
        add_marker(3, 1'b1);
        wait_drained();

        add_random_buffers(200);
        // sender holds off until every result is out
        wait_drained();
        add_random_buffers(190);

        wait_drained();
        repeat (40) @(posedge clk);
        if (fail_cnt == 0 && cipher_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
